/* hdl/mmd_pkg.sv */
// ============================================================================
// mmd_pkg
// Shared types, widths, constants and the screen-row helper of the min/max
// peak decimator.
// ============================================================================
package mmd_pkg;

    // Field and register widths.
    localparam int SAMPLE_W     = 16;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 9;
    localparam int TOTAL_W      = 32;
    localparam int CHAN_W       = 4;
    localparam int PHASE_W      = 3;
    localparam int STRIDE_SHIFT = 8;
    localparam int STRIDE_W     = TOTAL_W - STRIDE_SHIFT;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    // Register reset values.
    localparam int RESET_TOTAL    = 1200;
    localparam int RESET_CHANNELS = 2;

    // Register indexes, taken from address bit 2.
    localparam logic REG_TOTAL_FRAMES  = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    // Channel count saturation point.
    localparam logic [CHAN_W-1:0] MAX_CHANNELS = 4'd8;

    // Row mapping: center row and scale over full range.
    localparam logic signed [9:0]  ROW_CENTER = 10'sd250;
    localparam logic signed [23:0] ROW_SCALE  = 24'sd150;
    localparam logic signed [23:0] ROUND_ADJ  = 24'sd32767;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam sample_t SAMPLE_MAX = 16'sh7fff;

    // One channel-0 word passed from the front end to the back end.
    typedef struct packed {
        sample_t sample;
        logic    restart;
    } item_t;

    // Screen row 250 - v*150/32768, quotient truncated toward zero.
    function automatic logic [ROW_W-1:0] row_of(input sample_t v);
        logic signed [23:0] prod;
        logic signed [23:0] adj;
        logic signed [9:0]  quo;
        logic signed [9:0]  row;
        prod = $signed({{8{v[SAMPLE_W-1]}}, v}) * ROW_SCALE;
        adj  = prod[23] ? prod + ROUND_ADJ : prod;
        quo  = {adj[23], adj[23:15]};
        row  = ROW_CENTER - quo;
        return row[ROW_W-1:0];
    endfunction

endpackage

/* hdl/mmd_stream_if.sv */
// ============================================================================
// mmd_stream_if
// Valid/ready stream interfaces for the input words and the column results.
// ============================================================================
interface mmd_in_if;
    logic              valid;
    logic              ready;
    mmd_pkg::sample_t  sample;
    logic              restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface mmd_out_if;
    logic                           valid;
    logic                           ready;
    logic [mmd_pkg::COL_W-1:0]      column;
    mmd_pkg::sample_t               peak_max;
    mmd_pkg::sample_t               peak_min;
    logic [mmd_pkg::ROW_W-1:0]      top_row;
    logic [mmd_pkg::ROW_W-1:0]      bottom_row;
    logic                           last;

    modport source (output valid, output column, output peak_max, output peak_min,
                    output top_row, output bottom_row, output last, input ready);
    modport sink   (input valid, input column, input peak_max, input peak_min,
                    input top_row, input bottom_row, input last, output ready);
endinterface

/* hdl/mmd_front.sv */
// ============================================================================
// mmd_front
// Accepts interleaved PCM words, tracks the channel phase and forwards only
// channel-0 words to the queue.
// ============================================================================
module mmd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          busy,
    input  logic [mmd_pkg::CHAN_W-1:0]    channel_count,
    input  logic                          queue_full,
    output logic                          push,
    output mmd_pkg::item_t                push_item,
    mmd_in_if.sink                        in_ch
);
    import mmd_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] cur_phase;
    logic [CHAN_W-1:0]  nch;
    logic [CHAN_W-1:0]  phase_inc;
    logic               accept;

    // Effective channel count: zero reads as one, saturate at eight.
    always_comb
    begin
        if (channel_count == '0)
            nch = CHAN_W'(1);
        else if (channel_count > MAX_CHANNELS)
            nch = MAX_CHANNELS;
        else
            nch = channel_count;
    end

    assign in_ch.ready = !busy && !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // A restart word is always channel 0 of frame 0.
    assign cur_phase = in_ch.restart ? '0 : phase_reg;
    assign phase_inc = {1'b0, cur_phase} + CHAN_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (clear)
            phase_next = '0;
        else if (accept)
            phase_next = (phase_inc >= nch) ? '0 : phase_inc[PHASE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

    // Only channel-0 transactions reach the back end.
    assign push              = accept && (cur_phase == '0);
    assign push_item.sample  = in_ch.sample;
    assign push_item.restart = in_ch.restart;

endmodule

/* hdl/mmd_queue.sv */
// ============================================================================
// mmd_queue
// Two-entry queue decoupling the front end from the back end.
// ============================================================================
module mmd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mmd_pkg::item_t   push_item,
    input  logic             pop,
    output mmd_pkg::item_t   head,
    output logic             empty,
    output logic             full
);
    import mmd_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/mmd_div.sv */
// ============================================================================
// mmd_div
// Splits the effective frame count into a quotient and remainder by the
// column count, multiplying by the scaled reciprocal of the count in
// low-half, high-half and quotient steps.
// ============================================================================
module mmd_div #(
    parameter int COLUMNS = 1200,
    parameter int RW      = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mmd_pkg::TOTAL_W-1:0]     dividend,
    output logic                            busy,
    output logic                            done,
    output logic [mmd_pkg::TOTAL_W-1:0]     tq,
    output logic [RW-1:0]                   tr
);
    import mmd_pkg::*;

    localparam int unsigned RESET_EFF = (RESET_TOTAL > COLUMNS) ? RESET_TOTAL : COLUMNS;
    localparam int unsigned RESET_TQ  = RESET_EFF / COLUMNS;
    localparam int unsigned RESET_TR  = RESET_EFF % COLUMNS;

    // Reciprocal of the column count, rounded up and scaled so that the
    // truncated product gives the exact quotient of any 32-bit dividend.
    localparam int              RECIP_SH = TOTAL_W + $clog2(COLUMNS);
    localparam longint unsigned RECIP    = ((64'd1 << RECIP_SH) + 64'(COLUMNS) - 64'd1)
                                           / 64'(COLUMNS);
    localparam int              RECIP_W  = TOTAL_W + 1;
    localparam int              HALF_W   = TOTAL_W / 2;
    localparam int              PART_W   = HALF_W + RECIP_W;
    localparam int              ACC_W    = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
    localparam logic [TOTAL_W-1:0] DIVISOR = TOTAL_W'(COLUMNS);

    typedef enum logic [4:0] {
        DIV_IDLE = 5'b00001,
        DIV_LOW  = 5'b00010,
        DIV_HIGH = 5'b00100,
        DIV_QUOT = 5'b01000,
        DIV_DONE = 5'b10000
    } div_state_t;

    div_state_t           state_reg;
    div_state_t           state_next;
    logic [TOTAL_W-1:0]   dvd_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [TOTAL_W-1:0]   tq_reg;
    logic [RW-1:0]        tr_reg;
    logic [HALF_W-1:0]    mul_in;
    logic [PART_W-1:0]    part;
    logic [TOTAL_W-1:0]   quo;
    logic [TOTAL_W-1:0]   quo_times_cols;
    logic [TOTAL_W-1:0]   rem_full;

    // Sequencing: low half product, high half product, quotient, done.
    always_comb
    begin
        state_next = state_reg;
        if (start)
            state_next = DIV_LOW;
        else
        begin
            unique case (state_reg)
                DIV_IDLE: state_next = DIV_IDLE;
                DIV_LOW:  state_next = DIV_HIGH;
                DIV_HIGH: state_next = DIV_QUOT;
                DIV_QUOT: state_next = DIV_DONE;
                DIV_DONE: state_next = DIV_IDLE;
                default:  state_next = DIV_IDLE;
            endcase
        end
    end

    // One 16 x 33 partial product per cycle: low dividend half, then high half.
    assign mul_in = (state_reg == DIV_LOW) ? dvd_reg[HALF_W-1:0] : dvd_reg[TOTAL_W-1:HALF_W];
    assign part   = {{RECIP_W{1'b0}}, mul_in} * {{HALF_W{1'b0}}, RECIP_K};

    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == DIV_LOW)
            acc_next = {{HALF_W{1'b0}}, part};
        else if (state_reg == DIV_HIGH)
            acc_next = acc_reg + {part, {HALF_W{1'b0}}};
    end

    // Quotient from the top of the product, remainder by multiply back.
    assign quo            = TOTAL_W'(acc_reg >> RECIP_SH);
    assign quo_times_cols = quo * DIVISOR;
    assign rem_full       = dvd_reg - quo_times_cols;

    // The done state comes up out of reset so the back end loads its
    // first-column state from the reset quotient.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_DONE;
            tq_reg    <= TOTAL_W'(RESET_TQ);
            tr_reg    <= RW'(RESET_TR);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_QUOT)
            begin
                tq_reg <= quo;
                tr_reg <= rem_full[RW-1:0];
            end
        end
    end

    // Working registers of the division.
    always_ff @(posedge clk)
    begin
        if (start)
            dvd_reg <= dividend;
        acc_reg <= acc_next;
    end

    assign busy = (state_reg != DIV_IDLE);
    assign done = (state_reg == DIV_DONE);
    assign tq   = tq_reg;
    assign tr   = tr_reg;

endmodule

/* hdl/mmd_back.sv */
// ============================================================================
// mmd_back
// Column accounting for channel-0 words: stride sampling, running peaks,
// incremental column boundaries and the registered result stage.
// ============================================================================
module mmd_back #(
    parameter int COLUMNS = 1200,
    parameter int RW      = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [mmd_pkg::TOTAL_W-1:0]     tq,
    input  logic [RW-1:0]                   tr,
    input  logic                            empty,
    input  mmd_pkg::item_t                  head,
    output logic                            pop,
    mmd_out_if.source                       out_ch
);
    import mmd_pkg::*;

    localparam int            CW       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] DIVISOR  = RW'(COLUMNS);

    // Column state.
    logic [CW-1:0]        col_reg,    col_next,    cur_col;
    logic [RW-1:0]        br_reg,     br_next,     cur_br;
    logic [TOTAL_W-1:0]   left_reg,   left_next,   cur_left;
    logic [STRIDE_W-1:0]  stride_reg, stride_next, cur_stride;
    logic [STRIDE_W-1:0]  sph_reg,    sph_next,    cur_sph;
    sample_t              max_reg,    max_next,    cur_max;
    sample_t              min_reg,    min_next,    cur_min;
    logic                 fin_reg,    fin_next,    cur_fin;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic [COL_W-1:0]     out_col_reg;
    sample_t              out_max_reg;
    sample_t              out_min_reg;
    logic [ROW_W-1:0]     out_top_reg;
    logic [ROW_W-1:0]     out_bot_reg;
    logic                 out_last_reg;

    logic [STRIDE_W-1:0]  init_stride;
    logic [STRIDE_W-1:0]  next_stride;
    logic [STRIDE_W-1:0]  sph_inc;
    logic [RW-1:0]        br_sum;
    logic                 carry;
    logic [TOTAL_W-1:0]   next_len;
    logic                 sampled;
    sample_t              upd_max;
    sample_t              upd_min;
    logic                 col_end;
    logic                 is_last;
    logic                 emit;

    // Stride of the first column, at least one.
    assign init_stride = (tq[TOTAL_W-1:STRIDE_SHIFT] == '0) ? STRIDE_W'(1)
                                                            : tq[TOTAL_W-1:STRIDE_SHIFT];

    // A restart word clears the counters before it is counted itself.
    always_comb
    begin
        if (head.restart)
        begin
            cur_col    = '0;
            cur_br     = tr;
            cur_left   = tq;
            cur_stride = init_stride;
            cur_sph    = '0;
            cur_max    = SAMPLE_MIN;
            cur_min    = SAMPLE_MAX;
            cur_fin    = 1'b0;
        end
        else
        begin
            cur_col    = col_reg;
            cur_br     = br_reg;
            cur_left   = left_reg;
            cur_stride = stride_reg;
            cur_sph    = sph_reg;
            cur_max    = max_reg;
            cur_min    = min_reg;
            cur_fin    = fin_reg;
        end
    end

    // Take a word when the result register has room for its result.
    assign pop = !empty && (!out_valid_reg || out_ch.ready);

    // Running peaks over the sampled frames.
    assign sampled = (cur_sph == '0);
    assign upd_max = (sampled && (head.sample > cur_max)) ? head.sample : cur_max;
    assign upd_min = (sampled && (head.sample < cur_min)) ? head.sample : cur_min;
    assign sph_inc = cur_sph + STRIDE_W'(1);

    // Next column length from the running remainder of k*T/COLUMNS.
    assign br_sum      = cur_br + tr;
    assign carry       = (br_sum >= DIVISOR);
    assign next_len    = tq + TOTAL_W'(carry);
    assign next_stride = (next_len[TOTAL_W-1:STRIDE_SHIFT] == '0) ? STRIDE_W'(1)
                                                                 : next_len[TOTAL_W-1:STRIDE_SHIFT];

    assign col_end = (cur_left == TOTAL_W'(1));
    assign is_last = (cur_col == LAST_COL);
    assign emit    = pop && !cur_fin && col_end;

    // Column state update.
    always_comb
    begin
        col_next    = col_reg;
        br_next     = br_reg;
        left_next   = left_reg;
        stride_next = stride_reg;
        sph_next    = sph_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        fin_next    = fin_reg;
        if (load)
        begin
            col_next    = '0;
            br_next     = tr;
            left_next   = tq;
            stride_next = init_stride;
            sph_next    = '0;
            max_next    = SAMPLE_MIN;
            min_next    = SAMPLE_MAX;
            fin_next    = 1'b0;
        end
        else if (pop)
        begin
            col_next    = cur_col;
            br_next     = cur_br;
            left_next   = cur_left;
            stride_next = cur_stride;
            sph_next    = cur_sph;
            max_next    = cur_max;
            min_next    = cur_min;
            fin_next    = cur_fin;
            if (!cur_fin)
            begin
                if (col_end && is_last)
                begin
                    fin_next = 1'b1;
                end
                else if (col_end)
                begin
                    col_next    = cur_col + CW'(1);
                    br_next     = carry ? br_sum - DIVISOR : br_sum;
                    left_next   = next_len;
                    stride_next = next_stride;
                    sph_next    = '0;
                    max_next    = SAMPLE_MIN;
                    min_next    = SAMPLE_MAX;
                end
                else
                begin
                    left_next = cur_left - TOTAL_W'(1);
                    sph_next  = (sph_inc >= cur_stride) ? '0 : sph_inc;
                    max_next  = upd_max;
                    min_next  = upd_min;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            br_reg     <= '0;
            left_reg   <= '0;
            stride_reg <= '0;
            sph_reg    <= '0;
            max_reg    <= SAMPLE_MIN;
            min_reg    <= SAMPLE_MAX;
            fin_reg    <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            br_reg     <= br_next;
            left_reg   <= left_next;
            stride_reg <= stride_next;
            sph_reg    <= sph_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            fin_reg    <= fin_next;
        end
    end

    // Result register valid flag.
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload with the screen rows of both peaks.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_col_reg  <= COL_W'(cur_col);
            out_max_reg  <= upd_max;
            out_min_reg  <= upd_min;
            out_top_reg  <= row_of(upd_max);
            out_bot_reg  <= row_of(upd_min);
            out_last_reg <= is_last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.column     = out_col_reg;
    assign out_ch.peak_max   = out_max_reg;
    assign out_ch.peak_min   = out_min_reg;
    assign out_ch.top_row    = out_top_reg;
    assign out_ch.bottom_row = out_bot_reg;
    assign out_ch.last       = out_last_reg;

endmodule

/* hdl/waveform_min_max_decimator.sv */
// ============================================================================
// waveform_min_max_decimator
// Min/max peak decimation of channel 0 of an interleaved PCM stream into
// display columns, with screen rows for both peaks.
// ============================================================================
// Usage:
//   in_ch  carries one interleaved 16-bit PCM word per transaction plus a
//          restart flag that marks the first word of a new waveform.
//   out_ch carries one transaction per finished column: column index, the
//          column's max and min and their screen rows; last flags the final
//          column, after which words give no result until a restart or a write.
//   The APB port holds total_frames (address 0) and channel_count
//   (address 4). A write clears all counters and recomputes the column
//   split by a reciprocal multiplication: in_ch.ready stays low while
//   the split is recomputed.
// Throughput is one word per cycle while the divider is idle and the queue
// is not full. A column's result passes from its last accepted channel-0
// word through the queue and the back end into the result register.
// Reset loads the default registers and holds in_ch.ready low for one
// cycle while the first column is set up. When out_ch stalls, the result
// register holds and the queue absorbs two more channel-0 words before
// in_ch.ready falls; words of other channels keep flowing until then.
// ============================================================================
module waveform_min_max_decimator #(
    parameter int COLUMNS = 1200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mmd_in_if.sink                          in_ch,
    mmd_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mmd_pkg::ADDR_W-1:0]      paddr,
    input  logic [mmd_pkg::DATA_W-1:0]      pwdata,
    output logic [mmd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import mmd_pkg::*;

    localparam int RW = $clog2(COLUMNS) + 1;

    logic [TOTAL_W-1:0]  total_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic                cfg_wr;
    logic [TOTAL_W-1:0]  new_total;
    logic [TOTAL_W-1:0]  eff_total;

    logic                div_busy;
    logic                div_done;
    logic [TOTAL_W-1:0]  tq;
    logic [RW-1:0]       tr;

    logic                push;
    item_t               push_item;
    logic                pop;
    item_t               head;
    logic                empty;
    logic                full;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_W'(RESET_TOTAL);
            chan_reg  <= CHAN_W'(RESET_CHANNELS);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TOTAL_FRAMES:  total_reg <= pwdata[TOTAL_W-1:0];
                REG_CHANNEL_COUNT: chan_reg  <= pwdata[CHAN_W-1:0];
                default:           total_reg <= total_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[2])
            REG_TOTAL_FRAMES:  prdata = DATA_W'(total_reg);
            REG_CHANNEL_COUNT: prdata = DATA_W'(chan_reg);
            default:           prdata = '0;
        endcase
    end

    // Frame count after the write, raised to at least one frame per column.
    assign new_total = (cfg_wr && (paddr[2] == REG_TOTAL_FRAMES)) ? pwdata[TOTAL_W-1:0]
                                                                 : total_reg;
    assign eff_total = (new_total < TOTAL_W'(COLUMNS)) ? TOTAL_W'(COLUMNS) : new_total;

    mmd_div #(
        .COLUMNS (COLUMNS),
        .RW      (RW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr),
        .dividend (eff_total),
        .busy     (div_busy),
        .done     (div_done),
        .tq       (tq),
        .tr       (tr)
    );

    mmd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (cfg_wr),
        .busy          (div_busy),
        .channel_count (chan_reg),
        .queue_full    (full),
        .push          (push),
        .push_item     (push_item),
        .in_ch         (in_ch)
    );

    mmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    mmd_back #(
        .COLUMNS (COLUMNS),
        .RW      (RW)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (div_done),
        .tq     (tq),
        .tr     (tr),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // Every column samples its first frame, so its max never falls below its min.
    a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.peak_max >= out_ch.peak_min) &&
                         (out_ch.top_row <= out_ch.bottom_row))
        else $error("column peaks out of order");

    // The final column flag only accompanies the last column index.
    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> (out_ch.column == COL_W'(COLUMNS - 1)))
        else $error("last flag on a column other than the final one");

    // Intake stops while the column split is being recomputed.
    a_cfg_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ch.ready)
        else $error("input accepted during column split recompute");

endmodule

/* verif/tb.sv */
// ============================================================================
// tb
// Self-checking testbench of the min/max peak decimator. A scoreboard class
// predicts each column result from every accepted PCM word. The results of
// the block are checked field by field, in order, against those predictions.
// The run covers directed extremes and restarts, one complete waveform up to
// its final column, and strided long columns. It also covers short, saturated
// and huge register settings, with random idling on both streams.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmd_pkg::*;

    localparam int          COLUMNS       = 1200;
    localparam int          CLK_PERIOD    = 10;
    localparam int          SETTLE_CYCLES = 10;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int          SHOWN_ERRORS  = 10;

    // One column result as it leaves the block.
    typedef struct packed {
        logic [COL_W-1:0] column;
        sample_t          peak_max;
        sample_t          peak_min;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic             last;
    } column_peaks_t;

    // Tracks the decimator state and holds the column results still owed.
    class peak_scoreboard;
        logic [TOTAL_W-1:0] total_frames;
        logic [CHAN_W-1:0]  channel_count;
        int unsigned        channel_phase;
        int unsigned        column_index;
        longint unsigned    frame_scaled;
        longint unsigned    boundary_scaled;
        int unsigned        stride;
        int unsigned        stride_phase;
        int                 running_max;
        int                 running_min;
        bit                 finished;
        column_peaks_t      owed_columns[$];
        int unsigned        mismatches;
        int unsigned        columns_checked;
        int unsigned        final_columns;

        // Frame count in use: short waveforms are widened to one frame per column.
        function longint unsigned frames_in_use();
            longint unsigned t;
            t = total_frames;
            if (t < COLUMNS)
                t = COLUMNS;
            return t;
        endfunction

        // Measuring stride of the column that ends at boundary_scaled.
        function int unsigned column_stride();
            longint unsigned col_end;
            longint unsigned col_start;
            longint unsigned st;
            col_end   = boundary_scaled / COLUMNS;
            col_start = (boundary_scaled - frames_in_use()) / COLUMNS;
            st        = (col_end - col_start) / 256;
            if (st < 1)
                st = 1;
            return int'(st);
        endfunction

        function void clear_counters();
            channel_phase   = 0;
            column_index    = 0;
            frame_scaled    = COLUMNS;
            boundary_scaled = frames_in_use();
            stride          = column_stride();
            stride_phase    = 0;
            running_max     = -32768;
            running_min     = 32767;
            finished        = 1'b0;
        endfunction

        function void power_on();
            total_frames  = RESET_TOTAL;
            channel_count = RESET_CHANNELS;
            clear_counters();
        endfunction

        // Any register write restarts the waveform.
        function void write_reg(logic idx, logic [DATA_W-1:0] value);
            if (idx == REG_TOTAL_FRAMES)
                total_frames = value;
            else
                channel_count = value[CHAN_W-1:0];
            clear_counters();
        endfunction

        // Screen row 250 - v*150/32768; SystemVerilog division truncates to zero.
        function logic [ROW_W-1:0] screen_row(int v);
            int r;
            r = 250 - (v * 150) / 32768;
            return r[ROW_W-1:0];
        endfunction

        // Advance the state by one accepted word and queue any column it closes.
        function void note_word(sample_t s, logic restart);
            int            v;
            int unsigned   nch;
            int unsigned   phase;
            bit            col_end;
            column_peaks_t peaks;
            v = int'(s);
            nch = channel_count;
            if (nch == 0)
                nch = 1;
            if (nch > MAX_CHANNELS)
                nch = MAX_CHANNELS;
            if (restart)
                clear_counters();
            if (finished)
                return;

            // Only channel 0 of each frame is measured.
            phase = channel_phase;
            channel_phase = (phase + 1 >= nch) ? 0 : phase + 1;
            if (phase != 0)
                return;

            if (stride_phase == 0) begin
                if (v > running_max)
                    running_max = v;
                if (v < running_min)
                    running_min = v;
            end
            stride_phase++;
            if (stride_phase >= stride)
                stride_phase = 0;

            col_end = (frame_scaled + COLUMNS) > boundary_scaled;
            frame_scaled += COLUMNS;
            if (!col_end)
                return;

            peaks.column     = column_index[COL_W-1:0];
            peaks.peak_max   = sample_t'(running_max);
            peaks.peak_min   = sample_t'(running_min);
            peaks.top_row    = screen_row(running_max);
            peaks.bottom_row = screen_row(running_min);
            peaks.last       = (column_index >= COLUMNS - 1);
            owed_columns.push_back(peaks);

            // The final column stops the waveform until the next restart.
            if (peaks.last) begin
                finished = 1'b1;
            end
            else begin
                column_index++;
                boundary_scaled += frames_in_use();
                stride       = column_stride();
                stride_phase = 0;
                running_max  = -32768;
                running_min  = 32767;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        // Compare one accepted result with the oldest owed column.
        function void check_column(column_peaks_t got);
            column_peaks_t exp;
            if (owed_columns.size() == 0) begin
                flag($sformatf("unexpected result for column %0d", got.column));
                return;
            end
            exp = owed_columns.pop_front();
            columns_checked++;
            if (got.last)
                final_columns++;
            if (got.column !== exp.column || got.peak_max !== exp.peak_max ||
                got.peak_min !== exp.peak_min || got.top_row !== exp.top_row ||
                got.bottom_row !== exp.bottom_row || got.last !== exp.last)
                flag($sformatf({"column result: expected col %0d max %0d min %0d ",
                                "rows %0d/%0d last %0b, got col %0d max %0d min %0d ",
                                "rows %0d/%0d last %0b"},
                               exp.column, exp.peak_max, exp.peak_min, exp.top_row,
                               exp.bottom_row, exp.last, got.column, got.peak_max,
                               got.peak_min, got.top_row, got.bottom_row, got.last));
        endfunction

        function int pending();
            return owed_columns.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    mmd_in_if  in_bus();
    mmd_out_if out_bus();

    peak_scoreboard sb;

    bit          tx_steady;
    bit          rx_steady;
    int unsigned burst_left;
    int unsigned rx_left;
    bit          rx_on;
    int unsigned words_sent;
    int unsigned reg_writes;

    waveform_min_max_decimator #(.COLUMNS(COLUMNS)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result receiver: always ready when steady, else ready and stall stretches of random kind and length.
    always @(negedge clk) begin
        if (rx_steady) begin
            out_bus.ready <= 1'b1;
        end
        else begin
            if (rx_left == 0) begin
                rx_on   = ($urandom_range(0, 2) != 0);
                rx_left = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 16);
            end
            rx_left--;
            out_bus.ready <= rx_on;
        end
    end

    // Result monitor.
    always @(posedge clk) begin : result_monitor
        column_peaks_t got;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got.column     = out_bus.column;
            got.peak_max   = out_bus.peak_max;
            got.peak_min   = out_bus.peak_min;
            got.top_row    = out_bus.top_row;
            got.bottom_row = out_bus.bottom_row;
            got.last       = out_bus.last;
            sb.check_column(got);
        end
    end

    // Watchdog: ends the run when no transaction of any kind completes for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (psel && penable && pready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] ERROR: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Send one PCM word; a new burst may start with a random gap.
    task automatic push_word(sample_t s, logic restart);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = tx_steady ? 0 : $urandom_range(0, 10);
            repeat (gap) begin
                @(negedge clk);
                in_bus.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_bus.valid   <= 1'b1;
        in_bus.sample  <= s;
        in_bus.restart <= restart;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        sb.note_word(s, restart);
        words_sent++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(0);
            3:       return sample_t'(-1);
            default: return sample_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random words, with a restart on about one word in restart_odds (0 = never).
    task automatic stream_words(int unsigned count, int unsigned restart_odds);
        logic restart;
        for (int unsigned i = 0; i < count; i++) begin
            restart = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
            push_word(pick_sample(), restart);
        end
    endtask

    // Hold the sender until every owed column has arrived and the pipeline is empty.
    task automatic wait_idle();
        @(negedge clk);
        in_bus.valid   <= 1'b0;
        in_bus.restart <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Register write followed by a read back, issued once the block is idle.
    task automatic cfg_write(logic idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] stored;
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        reg_writes++;

        // Back-to-back read of the same register.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;

        stored = (idx == REG_CHANNEL_COUNT) ? DATA_W'(value[CHAN_W-1:0]) : value;
        if (readback !== stored)
            sb.flag($sformatf("register %0d read back 0x%08h, expected 0x%08h",
                              idx, readback, stored));
    endtask

    initial begin
        sb = new();
        sb.power_on();
        rst_n          = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.sample  = '0;
        in_bus.restart = 1'b0;
        out_bus.ready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        tx_steady      = 1'b1;
        rx_steady      = 1'b1;
        burst_left     = 0;
        rx_left        = 0;
        words_sent     = 0;
        reg_writes     = 0;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings: two channels, one frame per column.
        push_word(SAMPLE_MAX, 1'b1);
        push_word(SAMPLE_MIN, 1'b0);
        push_word(SAMPLE_MIN, 1'b0);
        push_word(SAMPLE_MAX, 1'b0);
        push_word(sample_t'(0), 1'b0);
        push_word(sample_t'(0), 1'b0);
        push_word(sample_t'(-1), 1'b0);
        push_word(sample_t'(1), 1'b0);
        push_word(sample_t'(1), 1'b0);
        push_word(sample_t'(-1), 1'b0);
        push_word(sample_t'(218), 1'b0);
        push_word(sample_t'(0), 1'b0);
        push_word(sample_t'(219), 1'b0);
        push_word(sample_t'(0), 1'b0);
        push_word(sample_t'(-219), 1'b0);
        push_word(sample_t'(0), 1'b0);
        push_word(sample_t'(-218), 1'b0);
        // Restart arriving in the channel 1 slot, then one at a frame boundary.
        push_word(sample_t'(77), 1'b1);
        push_word(sample_t'(-5), 1'b0);
        push_word(SAMPLE_MIN, 1'b1);
        push_word(SAMPLE_MAX, 1'b0);
        push_word(sample_t'(16'h5555), 1'b0);
        push_word(sample_t'(16'haaaa), 1'b0);

        // Sender pauses mid-stream until everything owed has been received.
        wait_idle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Zero frame total and zero channels: one whole waveform through its final
        // column, then words that must be ignored, then a restart.
        cfg_write(REG_TOTAL_FRAMES, 32'd0);
        cfg_write(REG_CHANNEL_COUNT, 32'd0);
        stream_words(COLUMNS + 20, 0);
        push_word(pick_sample(), 1'b1);
        stream_words(10, 0);

        // Just below the column count with eight channels, random restarts.
        cfg_write(REG_TOTAL_FRAMES, 32'(COLUMNS - 1));
        cfg_write(REG_CHANNEL_COUNT, 32'd8);
        stream_words(60, 25);

        // Uneven columns and a saturating channel count.
        cfg_write(REG_CHANNEL_COUNT, 32'd15);
        cfg_write(REG_TOTAL_FRAMES, 32'($urandom_range(COLUMNS + 1, 3 * COLUMNS)));
        stream_words(100, 40);

        // Largest frame total: nothing closes within the few words sent.
        cfg_write(REG_TOTAL_FRAMES, 32'hffff_ffff);
        cfg_write(REG_CHANNEL_COUNT, 32'd1);
        stream_words(30, 0);

        // 512-frame columns measured on every second frame.
        cfg_write(REG_TOTAL_FRAMES, 32'(COLUMNS * 512));
        stream_words(530, 0);

        // Back to the reset settings with no idling on either side.
        cfg_write(REG_TOTAL_FRAMES, 32'(RESET_TOTAL));
        cfg_write(REG_CHANNEL_COUNT, 32'(RESET_CHANNELS));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        stream_words(40, 30);

        wait_idle();

        $display("Sent %0d PCM words and checked %0d column results, %0d of them final.",
                 words_sent, sb.columns_checked, sb.final_columns);
        $display("Made %0d register writes over frame totals 0 to 4294967295 and %s",
                 reg_writes, "channel counts 0 to 15.");
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
